FILE: rtl/hebp_pkg.sv
// shared types, constants and codes for the huffman encoder bit packer
package hebp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int SYM_W     = 8;
  localparam int CODE_IN_W = 32;
  localparam int LEN_IN_W  = 6;
  localparam int BYTE_W    = 8;
  localparam int BCNT_W    = 4;
  localparam int PEND_W    = 7;
  localparam int PCNT_W    = 3;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [SYM_W-1:0]     symbol;
    logic [CODE_IN_W-1:0] code_bits;
    logic [LEN_IN_W-1:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic [BCNT_W-1:0] bit_count;
    logic              last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic read;
    logic align;
    logic emit;
    logic commit;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sym_hit;
    logic len_zero;
    logic cnt_ge8;
    logic slot_free;
  } status_t;

endpackage

FILE: rtl/huffman_encoder_bit_packer.sv
// top level of the table-driven huffman encoder with byte packer
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall   hebp_pkg::in_word_t
//   out_     output     out_valid / out_stall hebp_pkg::out_word_t
//
// a load is written while idle; a flush waits in its flush step through any output
// stall; an encode passes the registered table read and the window align step, then
// emits its n packed bytes (0 to 4) one byte per cycle through the output register unless the output stalls.
// rst_n is synchronous; it clears the controller, the table valid bits,
// the pending bits and the output valid. output stalls hold the controller
// in its emit or flush step; in_stall is high whenever a word is in progress.
module huffman_encoder_bit_packer #(
  parameter int MAX_CODE_LEN = hebp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hebp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hebp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hebp_pkg::out_word_t out_data
);

  hebp_pkg::cmd_t    cmd;
  hebp_pkg::status_t status;

  hebp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hebp_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a partial byte only ever closes a word
  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bit_count != hebp_pkg::BCNT_W'(hebp_pkg::BYTE_W)
      |-> out_data.last)
    else $error("partial byte without last");

  // while a non-final byte waits, the encoder is still busy with its word
  a_busy_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken in the middle of an encoded word");

  // a flush into an empty output slot passes the flush step and then shows its single result
  a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == hebp_pkg::OP_FLUSH && !out_valid
      |=> ##1 out_valid && out_data.last)
    else $error("flush result missing");

endmodule

FILE: rtl/hebp_ram.sv
// generic single-write, single-read ram with registered read data
module hebp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/hebp_dp.sv
// datapath: code table, bit window, pending bits and output register
module hebp_dp #(
  parameter int MAX_CODE_LEN = hebp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hebp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hebp_pkg::in_word_t  in_data,
  input  logic                out_stall,
  input  hebp_pkg::cmd_t      cmd,
  output hebp_pkg::status_t   status,
  output logic                out_valid,
  output hebp_pkg::out_word_t out_data
);

  localparam int CODE_W = (MAX_CODE_LEN > hebp_pkg::CODE_IN_W) ? hebp_pkg::CODE_IN_W
                                                                : MAX_CODE_LEN;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int WIN_W  = CODE_W + hebp_pkg::BYTE_W;
  localparam int CNT_W  = $clog2(WIN_W + 1);
  localparam int ADDR_W = $clog2(SYMBOL_COUNT);
  localparam int ENT_W  = CODE_W + LEN_W;

  logic [SYMBOL_COUNT-1:0]     vld_r;
  logic [ADDR_W-1:0]           addr;
  logic                        sym_ok;
  logic [LEN_W-1:0]            len_sat;
  logic                        wr_en;
  logic [ENT_W-1:0]            rd_data;
  logic [LEN_W-1:0]            rd_len;
  logic [CODE_W-1:0]           rd_code;
  logic [CODE_W-1:0]           code_left;
  logic [WIN_W-1:0]            win_r, win_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [hebp_pkg::PEND_W-1:0] pend_r;
  logic [hebp_pkg::PCNT_W-1:0] pcnt_r;
  logic                        out_valid_r;
  hebp_pkg::out_word_t         out_data_r;
  logic                        slot_free;

  assign sym_ok = {1'b0, in_data.symbol} < (hebp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  assign addr   = in_data.symbol[ADDR_W-1:0];

  // saturate the length to what the table can hold
  assign len_sat = (in_data.code_length > hebp_pkg::LEN_IN_W'(CODE_W))
                 ? LEN_W'(CODE_W) : LEN_W'(in_data.code_length);

  assign wr_en = cmd.load && sym_ok;

  hebp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data ({len_sat, in_data.code_bits[CODE_W-1:0]}),
    .rd_en   (cmd.read),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign rd_len  = rd_data[CODE_W +: LEN_W];
  assign rd_code = rd_data[CODE_W-1:0];

  // left-align the code, dropping bits above its length, then place it after the pending bits
  assign code_left = rd_code << (LEN_W'(CODE_W) - rd_len);
  assign win_nxt   = {pend_r, {(WIN_W - hebp_pkg::PEND_W){1'b0}}}
                   | ({code_left, {hebp_pkg::BYTE_W{1'b0}}} >> pcnt_r);
  assign cnt_nxt   = CNT_W'(pcnt_r) + CNT_W'(rd_len);

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.align) begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end else if (cmd.emit) begin
      win_r <= win_r << hebp_pkg::BYTE_W;
      cnt_r <= cnt_r - CNT_W'(hebp_pkg::BYTE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else if (cmd.commit) begin
      pend_r <= win_r[WIN_W-1 -: hebp_pkg::PEND_W];
      pcnt_r <= cnt_r[hebp_pkg::PCNT_W-1:0];
    end else if (cmd.flush) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.packed_byte <= win_r[WIN_W-1 -: hebp_pkg::BYTE_W];
      out_data_r.bit_count   <= hebp_pkg::BCNT_W'(hebp_pkg::BYTE_W);
      // last full byte when fewer than sixteen bits are in the window
      out_data_r.last        <= (cnt_r >> 3) == CNT_W'(1);
    end else if (cmd.flush) begin
      out_data_r.packed_byte <= {pend_r, 1'b0};
      out_data_r.bit_count   <= {1'b0, pcnt_r};
      out_data_r.last        <= 1'b1;
    end
  end

  assign status.sym_hit   = sym_ok && vld_r[addr];
  assign status.len_zero  = rd_len == '0;
  assign status.cnt_ge8   = (cnt_r >> 3) != '0;
  assign status.slot_free = slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/hebp_ctrl.sv
// controller: sequences load, encode and flush words
module hebp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  input  hebp_pkg::status_t status,
  output logic              in_stall,
  output hebp_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            hebp_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            hebp_pkg::OP_ENCODE: begin
              // unknown or unused symbols produce nothing
              if (status.sym_hit) begin
                cmd.read  = 1'b1;
                state_nxt = S_ALIGN;
              end
            end
            hebp_pkg::OP_FLUSH: begin
              state_nxt = S_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      S_ALIGN: begin
        if (status.len_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.align = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.cnt_ge8) begin
          cmd.emit = status.slot_free;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule
